/* sv/tccc_pkg.sv */
package tccc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_PRE  = 3'd1,
        PH_CC   = 3'd2,
        PH_CV   = 3'd3,
        PH_DONE = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        CFG_DUTY_LIMIT     = 3'd0,
        CFG_USB_CUTOFF     = 3'd1,
        CFG_PRE_EXIT_V     = 3'd2,
        CFG_CV_PACK_V      = 3'd3,
        CFG_CV_CELL_V      = 3'd4,
        CFG_RECHG_PACK_V   = 3'd5,
        CFG_RECHG_CELL_V   = 3'd6,
        CFG_CELL_OV        = 3'd7
    } t_cfg_idx;

    localparam int CFG_DATA_W = 12;

    typedef struct packed {
        logic        usb_present;
        logic [9:0]  pack_voltage;
        logic [9:0]  lower_cell_voltage;
        logic [11:0] charge_current;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  pwm_duty;
        logic        charging;
        logic [2:0]  charge_phase;
        logic [10:0] target_current;
    } t_out_item;

    localparam logic [9:0]  FULL_PACK_AT_IDLE = 10'd845;
    localparam logic [10:0] GOAL_PRE          = 11'd500;
    localparam logic [10:0] GOAL_CC           = 11'd1050;
    localparam logic [10:0] GOAL_CV_START     = 11'd1000;
    localparam logic [10:0] GOAL_END          = 11'd200;
    localparam logic [10:0] GOAL_STEP         = 11'd100;
    localparam logic [10:0] GOAL_MIN_ACTIVE   = 11'd50;
    localparam logic [5:0]  TAPER_TICKS       = 6'd50;

    localparam logic [7:0]  PERIOD_RESET      = 8'd200;
    localparam logic [7:0]  PERIOD_FAST       = 8'd30;
    localparam logic [7:0]  PERIOD_QUICK      = 8'd40;
    localparam logic [7:0]  PERIOD_MID        = 8'd80;
    localparam logic [7:0]  PERIOD_SLOW       = 8'd130;

    localparam logic [11:0] ERR_DEADBAND      = 12'd80;
    localparam logic [11:0] ERR_BAND_900      = 12'd900;
    localparam logic [11:0] ERR_BAND_800      = 12'd800;
    localparam logic [11:0] ERR_BAND_650      = 12'd650;
    localparam logic [11:0] ERR_BAND_500      = 12'd500;
    localparam logic [11:0] ERR_BAND_350      = 12'd350;

    localparam logic [7:0]  RST_DUTY_LIMIT    = 8'd130;
    localparam logic [11:0] RST_USB_CUTOFF    = 12'd1500;
    localparam logic [9:0]  RST_PRE_EXIT_V    = 10'd560;
    localparam logic [9:0]  RST_CV_PACK_V     = 10'd840;
    localparam logic [9:0]  RST_CV_CELL_V     = 10'd420;
    localparam logic [9:0]  RST_RECHG_PACK_V  = 10'd820;
    localparam logic [9:0]  RST_RECHG_CELL_V  = 10'd400;
    localparam logic [9:0]  RST_CELL_OV       = 10'd425;

endpackage

/* sv/tccc_if.sv */
interface tccc_in_if
    import tccc_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface tccc_out_if
    import tccc_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface tccc_cfg_if
    import tccc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    t_cfg_idx              idx;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output idx, output data, input ready);
    modport sink (input valid, input idx, input data, output ready);
endinterface

/* sv/two_cell_cc_cv_charger_top.sv */
// Two-cell CC/CV charge controller. Each input beat is one control tick carrying USB presence,
// pack voltage, mid-point voltage and charge current; each tick returns exactly one result beat
// with the PWM duty, the charging flag, the phase and the target current. A beat lands in an
// input register, the whole tick (phase, overvoltage, duty adjust, period count) is worked out
// combinationally from that register and the state, and the result sits in an output register.
// One beat is accepted every cycle while the output side takes results. Configuration writes are
// always accepted and take effect on the next tick; write them only while no tick is in flight.
module two_cell_cc_cv_charger_top
    import tccc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tccc_in_if.sink    i_in,
    tccc_out_if.source o_out,
    tccc_cfg_if.sink   i_cfg
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [7:0]  r_duty_limit;
    logic [11:0] r_usb_cutoff;
    logic [9:0]  r_pre_exit_v;
    logic [9:0]  r_cv_pack_v;
    logic [9:0]  r_cv_cell_v;
    logic [9:0]  r_rechg_pack_v;
    logic [9:0]  r_rechg_cell_v;
    logic [9:0]  r_cell_ov;

    t_phase      r_phase;
    logic [7:0]  r_duty;
    logic [10:0] r_goal;
    logic [5:0]  r_taper;
    logic [7:0]  r_adj_period;
    logic [7:0]  r_period_cnt;
    logic        r_adj_pending;

    t_phase      n_phase;
    logic [7:0]  n_duty;
    logic [10:0] n_goal;
    logic [5:0]  n_taper;
    logic [7:0]  n_adj_period;
    logic [7:0]  n_period_cnt;
    logic        n_adj_pending;
    t_out_item   n_out;

    logic        advance;
    logic signed [11:0] upper_cell;
    logic        is_high;
    logic        over_volt;
    logic        recharge;
    logic        charging;
    logic [5:0]  taper_inc;
    logic [7:0]  period_inc;
    logic [7:0]  adj_duty;
    logic        adj_down;
    logic [11:0] adj_err;
    logic [11:0] goal_ext;
    logic [1:0]  adj_step;
    logic [8:0]  adj_sum;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;
    assign i_cfg.ready = 1'b1;

    assign upper_cell = $signed({2'b00, r_in.pack_voltage})
                      - $signed({2'b00, r_in.lower_cell_voltage});
    assign is_high    = (r_in.pack_voltage > r_cv_pack_v)
                     || (r_in.lower_cell_voltage > r_cv_cell_v)
                     || (upper_cell > $signed({2'b00, r_cv_cell_v}));
    assign over_volt  = (r_in.lower_cell_voltage > r_cell_ov)
                     || (upper_cell > $signed({2'b00, r_cell_ov}));
    assign recharge   = (r_in.pack_voltage < r_rechg_pack_v)
                     && (r_in.lower_cell_voltage < r_rechg_cell_v)
                     && (upper_cell < $signed({2'b00, r_rechg_cell_v}));
    assign taper_inc  = r_taper + 6'd1;
    assign period_inc = r_period_cnt + 8'd1;

    always_comb begin
        n_phase       = r_phase;
        n_duty        = r_duty;
        n_goal        = r_goal;
        n_taper       = r_taper;
        n_adj_period  = r_adj_period;
        n_period_cnt  = r_period_cnt;
        n_adj_pending = r_adj_pending;
        adj_duty      = '0;
        adj_down      = 1'b0;
        adj_err       = '0;
        goal_ext      = '0;
        adj_step      = '0;
        adj_sum       = '0;

        if (!r_in.usb_present) begin
            n_phase       = PH_IDLE;
            n_duty        = '0;
            n_adj_pending = 1'b0;
            n_taper       = '0;
            n_adj_period  = PERIOD_RESET;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (r_in.pack_voltage > FULL_PACK_AT_IDLE) begin
                        n_phase = PH_DONE;
                        n_goal  = '0;
                    end else begin
                        n_duty  = '0;
                        n_phase = PH_PRE;
                    end
                end
                PH_PRE: begin
                    n_goal = GOAL_PRE;
                    if (r_in.pack_voltage > r_pre_exit_v) begin
                        n_taper = '0;
                        n_phase = PH_CC;
                    end
                end
                PH_CC: begin
                    n_goal = GOAL_CC;
                    if (is_high) begin
                        n_goal  = GOAL_CV_START;
                        n_phase = PH_CV;
                    end
                end
                PH_CV: begin
                    n_taper = taper_inc;
                    if (taper_inc >= TAPER_TICKS) begin
                        n_taper = '0;
                        if (is_high) begin
                            if (r_goal > GOAL_END) begin
                                n_goal = r_goal - GOAL_STEP;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                end
                PH_DONE: begin
                    if (recharge) begin
                        n_taper = '0;
                        n_phase = PH_CV;
                    end
                end
                default: begin
                end
            endcase
        end

        charging = (n_phase == PH_PRE) || (n_phase == PH_CC) || (n_phase == PH_CV);
        if (charging && over_volt) begin
            n_phase = PH_DONE;
        end

        if (n_adj_pending) begin
            n_adj_pending = 1'b0;
            adj_duty = (n_duty > r_duty_limit) ? r_duty_limit : n_duty;
            if (r_in.charge_current > r_usb_cutoff) begin
                adj_duty = '0;
            end
            if (n_goal <= GOAL_MIN_ACTIVE) begin
                adj_duty = '0;
            end else begin
                goal_ext = {1'b0, n_goal};
                adj_down = goal_ext < r_in.charge_current;
                adj_err  = adj_down ? (r_in.charge_current - goal_ext)
                                    : (goal_ext - r_in.charge_current);
                priority if (adj_err < ERR_DEADBAND) begin
                    adj_step = 2'd0; n_adj_period = PERIOD_RESET;
                end else if (adj_err > ERR_BAND_900) begin
                    adj_step = 2'd3; n_adj_period = PERIOD_FAST;
                end else if (adj_err > ERR_BAND_800) begin
                    adj_step = 2'd2; n_adj_period = PERIOD_QUICK;
                end else if (adj_err > ERR_BAND_650) begin
                    adj_step = 2'd1; n_adj_period = PERIOD_QUICK;
                end else if (adj_err > ERR_BAND_500) begin
                    adj_step = 2'd1; n_adj_period = PERIOD_MID;
                end else if (adj_err > ERR_BAND_350) begin
                    adj_step = 2'd1; n_adj_period = PERIOD_SLOW;
                end else begin
                    adj_step = 2'd1; n_adj_period = PERIOD_RESET;
                end
                if (adj_down) begin
                    adj_duty = (adj_duty < {6'd0, adj_step}) ? 8'd0
                                                             : adj_duty - {6'd0, adj_step};
                end else begin
                    adj_sum  = {1'b0, adj_duty} + {7'd0, adj_step};
                    adj_duty = (adj_sum > {1'b0, r_duty_limit}) ? r_duty_limit
                                                                : adj_sum[7:0];
                end
            end
            n_duty = adj_duty;
        end

        n_out.charging       = charging;
        n_out.charge_phase   = n_phase;
        n_out.target_current = n_goal;
        if (charging) begin
            n_period_cnt = period_inc;
            if (period_inc >= n_adj_period) begin
                n_period_cnt  = '0;
                n_adj_pending = 1'b1;
            end
            n_out.pwm_duty = n_duty;
        end else begin
            n_period_cnt   = '0;
            n_out.pwm_duty = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_limit   <= RST_DUTY_LIMIT;
            r_usb_cutoff   <= RST_USB_CUTOFF;
            r_pre_exit_v   <= RST_PRE_EXIT_V;
            r_cv_pack_v    <= RST_CV_PACK_V;
            r_cv_cell_v    <= RST_CV_CELL_V;
            r_rechg_pack_v <= RST_RECHG_PACK_V;
            r_rechg_cell_v <= RST_RECHG_CELL_V;
            r_cell_ov      <= RST_CELL_OV;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.idx)
                CFG_DUTY_LIMIT:   r_duty_limit   <= i_cfg.data[7:0];
                CFG_USB_CUTOFF:   r_usb_cutoff   <= i_cfg.data[11:0];
                CFG_PRE_EXIT_V:   r_pre_exit_v   <= i_cfg.data[9:0];
                CFG_CV_PACK_V:    r_cv_pack_v    <= i_cfg.data[9:0];
                CFG_CV_CELL_V:    r_cv_cell_v    <= i_cfg.data[9:0];
                CFG_RECHG_PACK_V: r_rechg_pack_v <= i_cfg.data[9:0];
                CFG_RECHG_CELL_V: r_rechg_cell_v <= i_cfg.data[9:0];
                CFG_CELL_OV:      r_cell_ov      <= i_cfg.data[9:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_duty        <= '0;
            r_goal        <= '0;
            r_taper       <= '0;
            r_adj_period  <= PERIOD_RESET;
            r_period_cnt  <= '0;
            r_adj_pending <= 1'b0;
        end else if (advance) begin
            r_phase       <= n_phase;
            r_duty        <= n_duty;
            r_goal        <= n_goal;
            r_taper       <= n_taper;
            r_adj_period  <= n_adj_period;
            r_period_cnt  <= n_period_cnt;
            r_adj_pending <= n_adj_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_idle_no_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.charging |-> r_out.pwm_duty == 8'd0)
        else $error("duty driven while not charging");

    a_taper_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taper < TAPER_TICKS)
        else $error("taper count out of range");

    a_usb_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in.usb_present |=> r_out.charge_phase == PH_IDLE && !r_adj_pending)
        else $error("usb loss did not return to idle");

    a_pending_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_adj_pending) |-> $past(advance) && $past(n_out.charging))
        else $error("adjust requested outside a charging tick");

endmodule

/* dv/charge_check.sv */
`timescale 1ns / 100ps
module charge_check
    import tccc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tccc_in_if   i_in,
    tccc_out_if  i_out,
    tccc_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_result_count
);

    logic [7:0]  duty_limit_q;
    logic [11:0] usb_cutoff_q;
    logic [9:0]  pre_exit_q;
    logic [9:0]  cv_pack_q;
    logic [9:0]  cv_cell_q;
    logic [9:0]  rechg_pack_q;
    logic [9:0]  rechg_cell_q;
    logic [9:0]  cell_ov_q;

    t_phase      phase_q;
    logic [7:0]  duty_q;
    logic [10:0] goal_q;
    logic [5:0]  taper_q;
    logic [7:0]  period_q;
    logic [7:0]  period_cnt_q;
    logic        adjust_due_q;

    t_out_item   tick_results_q[$];

    function automatic bit voltage_high(int pack, int mid);
        return pack > int'(cv_pack_q) || mid > int'(cv_cell_q) || (pack - mid) > int'(cv_cell_q);
    endfunction

    function automatic void trim_duty(int cur);
        int  d;
        int  g;
        int  err;
        int  stp;
        bit  down;
        d = duty_q;
        g = goal_q;
        if (d > int'(duty_limit_q)) d = duty_limit_q;
        if (cur > int'(usb_cutoff_q)) d = 0;
        if (g <= int'(GOAL_MIN_ACTIVE)) begin
            duty_q = '0;
            return;
        end
        down = g < cur;
        err  = down ? cur - g : g - cur;
        if (err < int'(ERR_DEADBAND)) begin
            stp = 0;
            period_q = PERIOD_RESET;
        end else if (err > int'(ERR_BAND_900)) begin
            stp = 3;
            period_q = PERIOD_FAST;
        end else if (err > int'(ERR_BAND_800)) begin
            stp = 2;
            period_q = PERIOD_QUICK;
        end else if (err > int'(ERR_BAND_650)) begin
            stp = 1;
            period_q = PERIOD_QUICK;
        end else if (err > int'(ERR_BAND_500)) begin
            stp = 1;
            period_q = PERIOD_MID;
        end else if (err > int'(ERR_BAND_350)) begin
            stp = 1;
            period_q = PERIOD_SLOW;
        end else begin
            stp = 1;
            period_q = PERIOD_RESET;
        end
        if (down) begin
            d = (d < stp) ? 0 : d - stp;
        end else begin
            d = d + stp;
            if (d > int'(duty_limit_q)) d = duty_limit_q;
        end
        duty_q = d[7:0];
    endfunction

    function automatic t_out_item tick_result(t_in_item it);
        int        pack;
        int        mid;
        int        cur;
        bit        chg;
        t_out_item r;
        pack = it.pack_voltage;
        mid  = it.lower_cell_voltage;
        cur  = it.charge_current;
        if (!it.usb_present) begin
            phase_q      = PH_IDLE;
            duty_q       = '0;
            adjust_due_q = 1'b0;
            taper_q      = '0;
            period_q     = PERIOD_RESET;
        end else begin
            case (phase_q)
                PH_IDLE: begin
                    if (pack > int'(FULL_PACK_AT_IDLE)) begin
                        phase_q = PH_DONE;
                        goal_q  = '0;
                    end else begin
                        duty_q  = '0;
                        phase_q = PH_PRE;
                    end
                end
                PH_PRE: begin
                    goal_q = GOAL_PRE;
                    if (pack > int'(pre_exit_q)) begin
                        taper_q = '0;
                        phase_q = PH_CC;
                    end
                end
                PH_CC: begin
                    goal_q = GOAL_CC;
                    if (voltage_high(pack, mid)) begin
                        goal_q  = GOAL_CV_START;
                        phase_q = PH_CV;
                    end
                end
                PH_CV: begin
                    taper_q = taper_q + 6'd1;
                    if (taper_q >= TAPER_TICKS) begin
                        taper_q = '0;
                        if (voltage_high(pack, mid)) begin
                            if (goal_q > GOAL_END) goal_q = goal_q - GOAL_STEP;
                            else phase_q = PH_DONE;
                        end
                    end
                end
                PH_DONE: begin
                    if (pack < int'(rechg_pack_q) && mid < int'(rechg_cell_q) &&
                        (pack - mid) < int'(rechg_cell_q)) begin
                        taper_q = '0;
                        phase_q = PH_CV;
                    end
                end
                default: begin
                end
            endcase
        end

        chg = phase_q inside {PH_PRE, PH_CC, PH_CV};
        if (chg && (mid > int'(cell_ov_q) || pack > int'(cell_ov_q) + mid)) phase_q = PH_DONE;

        if (adjust_due_q) begin
            adjust_due_q = 1'b0;
            trim_duty(cur);
        end

        if (chg) begin
            period_cnt_q = period_cnt_q + 8'd1;
            if (period_cnt_q >= period_q) begin
                period_cnt_q = '0;
                adjust_due_q = 1'b1;
            end
            r.pwm_duty = duty_q;
        end else begin
            period_cnt_q = '0;
            r.pwm_duty   = '0;
        end
        r.charging       = chg;
        r.charge_phase   = phase_q;
        r.target_current = goal_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            duty_limit_q   = RST_DUTY_LIMIT;
            usb_cutoff_q   = RST_USB_CUTOFF;
            pre_exit_q     = RST_PRE_EXIT_V;
            cv_pack_q      = RST_CV_PACK_V;
            cv_cell_q      = RST_CV_CELL_V;
            rechg_pack_q   = RST_RECHG_PACK_V;
            rechg_cell_q   = RST_RECHG_CELL_V;
            cell_ov_q      = RST_CELL_OV;
            phase_q        = PH_IDLE;
            duty_q         = '0;
            goal_q         = '0;
            taper_q        = '0;
            period_q       = PERIOD_RESET;
            period_cnt_q   = '0;
            adjust_due_q   = 1'b0;
            o_fail_count   = 0;
            o_result_count = 0;
            tick_results_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = i_out.item;
                o_result_count++;
                if (tick_results_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result beat with no tick pending: duty %0d chg %0d phase %0d goal %0d",
                                 $time, got.pwm_duty, got.charging, got.charge_phase,
                                 got.target_current);
                    o_fail_count++;
                end else begin
                    want = tick_results_q.pop_front();
                    if (got.pwm_duty !== want.pwm_duty || got.charging !== want.charging ||
                        got.charge_phase !== want.charge_phase ||
                        got.target_current !== want.target_current) begin
                        if (o_fail_count < 10)
                            $display("%0t: result %0d: exp duty %0d chg %0d phase %0d goal %0d, got duty %0d chg %0d phase %0d goal %0d",
                                     $time, o_result_count, want.pwm_duty, want.charging,
                                     want.charge_phase, want.target_current, got.pwm_duty,
                                     got.charging, got.charge_phase, got.target_current);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.idx)
                    CFG_DUTY_LIMIT:   duty_limit_q = i_cfg.data[7:0];
                    CFG_USB_CUTOFF:   usb_cutoff_q = i_cfg.data[11:0];
                    CFG_PRE_EXIT_V:   pre_exit_q   = i_cfg.data[9:0];
                    CFG_CV_PACK_V:    cv_pack_q    = i_cfg.data[9:0];
                    CFG_CV_CELL_V:    cv_cell_q    = i_cfg.data[9:0];
                    CFG_RECHG_PACK_V: rechg_pack_q = i_cfg.data[9:0];
                    CFG_RECHG_CELL_V: rechg_cell_q = i_cfg.data[9:0];
                    CFG_CELL_OV:      cell_ov_q    = i_cfg.data[9:0];
                    default: begin
                    end
                endcase
            end
            if (i_in.valid && i_in.ready) tick_results_q.push_back(tick_result(i_in.item));
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
module testbench;
    import tccc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [7:0]  duty_limit;
        logic [11:0] usb_cutoff;
        logic [9:0]  pre_exit;
        logic [9:0]  cv_pack;
        logic [9:0]  cv_cell;
        logic [9:0]  rechg_pack;
        logic [9:0]  rechg_cell;
        logic [9:0]  cell_ov;
    } t_charge_settings;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm = 1'b0;
    int   ticks_sent = 0;
    int   fail_count;
    int   results_seen;
    int   quiet_cycles = 0;

    tccc_in_if  tick_ch ();
    tccc_out_if result_ch ();
    tccc_cfg_if cfg_ch ();

    two_cell_cc_cv_charger_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (tick_ch),
        .o_out   (result_ch),
        .i_cfg   (cfg_ch)
    );

    charge_check charge_mon (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in           (tick_ch),
        .i_out          (result_ch),
        .i_cfg          (cfg_ch),
        .o_fail_count   (fail_count),
        .o_result_count (results_seen)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stall the result side in bursts
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 11) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    function automatic int clip10(int v);
        return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
    endfunction

    function automatic t_in_item mk_tick(bit usb, int pack, int mid, int cur);
        t_in_item it;
        it.usb_present        = usb;
        it.pack_voltage       = pack[9:0];
        it.lower_cell_voltage = mid[9:0];
        it.charge_current     = cur[11:0];
        return it;
    endfunction

    function automatic t_in_item any_tick();
        return mk_tick(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 4095));
    endfunction

    function automatic t_charge_settings mk_settings(int lim, int cutoff, int pre_exit,
                                                     int cv_pack, int cv_cell, int rc_pack,
                                                     int rc_cell, int ov);
        t_charge_settings s;
        s.duty_limit = lim[7:0];
        s.usb_cutoff = cutoff[11:0];
        s.pre_exit   = pre_exit[9:0];
        s.cv_pack    = cv_pack[9:0];
        s.cv_cell    = cv_cell[9:0];
        s.rechg_pack = rc_pack[9:0];
        s.rechg_cell = rc_cell[9:0];
        s.cell_ov    = ov[9:0];
        return s;
    endfunction

    task automatic put_tick(input t_in_item it);
        if (!calm && $urandom_range(0, 11) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        tick_ch.item  <= it;
        tick_ch.valid <= 1'b1;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        ticks_sent++;
    endtask

    // hold off until every tick has its result beat
    task automatic drain_ticks();
        tick_ch.valid <= 1'b0;
        while (results_seen != ticks_sent) @(posedge clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [11:0] val, input bit last);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        if (last) cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_settings(input t_charge_settings s);
        cfg_write(CFG_DUTY_LIMIT, 12'(s.duty_limit), 1'b0);
        cfg_write(CFG_USB_CUTOFF, s.usb_cutoff, 1'b0);
        cfg_write(CFG_PRE_EXIT_V, 12'(s.pre_exit), 1'b0);
        cfg_write(CFG_CV_PACK_V, 12'(s.cv_pack), 1'b0);
        cfg_write(CFG_CV_CELL_V, 12'(s.cv_cell), 1'b0);
        cfg_write(CFG_RECHG_PACK_V, 12'(s.rechg_pack), 1'b0);
        cfg_write(CFG_RECHG_CELL_V, 12'(s.rechg_cell), 1'b0);
        cfg_write(CFG_CELL_OV, 12'(s.cell_ov), 1'b1);
    endtask

    // pack climbs with occasional sags; cells roughly balanced
    task automatic charge_session(input int n, input int pack0, input int climb, input int skew,
                                  input int noise_pct, input int unplug_per_mille);
        int       pack;
        int       mid;
        int       cur;
        t_in_item it;
        pack = pack0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                it = any_tick();
            end else begin
                pack = pack + int'($urandom_range(0, climb));
                if ($urandom_range(0, 39) == 0) pack = pack - int'($urandom_range(0, 80));
                pack = clip10(pack);
                mid  = clip10(pack / 2 + int'($urandom_range(0, 2 * skew)) - skew);
                cur  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 1300);
                it   = mk_tick($urandom_range(0, 999) >= unplug_per_mille, pack, mid, cur);
            end
            put_tick(it);
        end
    endtask

    initial begin
        rst_n         <= 1'b0;
        tick_ch.valid <= 1'b0;
        tick_ch.item  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.idx    <= CFG_DUTY_LIMIT;
        cfg_ch.data   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        put_tick(mk_tick(1'b0, 0, 0, 0));
        put_tick(mk_tick(1'b1, 900, 450, 0));
        put_tick(mk_tick(1'b1, 1023, 1023, 4095));
        put_tick(mk_tick(1'b1, 300, 150, 100));
        put_tick(mk_tick(1'b0, 1023, 0, 4095));
        put_tick(mk_tick(1'b1, 300, 150, 0));
        put_tick(mk_tick(1'b1, 300, 150, 600));
        put_tick(mk_tick(1'b1, 561, 280, 4095));
        put_tick(mk_tick(1'b1, 700, 350, 1000));
        put_tick(mk_tick(1'b1, 700, 0, 0));
        put_tick(mk_tick(1'b1, 100, 50, 0));
        put_tick(mk_tick(1'b1, 500, 1023, 0));
        put_tick(mk_tick(1'b0, 0, 0, 0));
        put_tick(mk_tick(1'b1, 0, 1023, 2048));
        put_tick(mk_tick(1'b1, 845, 422, 1));
        put_tick(mk_tick(1'b0, 845, 0, 0));
        put_tick(mk_tick(1'b1, 845, 0, 0));
        put_tick(mk_tick(1'b1, 512, 511, 1365));
        put_tick(mk_tick(1'b0, 341, 682, 2730));

        charge_session(180, 520, 4, 30, 10, 15);
        drain_ticks();
        apply_settings(mk_settings(0, 0, 0, 0, 0, 0, 0, 0));
        charge_session(50, 0, 3, 40, 20, 20);
        drain_ticks();
        apply_settings(mk_settings(255, 4095, 1023, 1023, 1023, 1023, 1023, 1023));
        charge_session(90, 100, 4, 300, 10, 10);
        drain_ticks();
        apply_settings(mk_settings(255, 4095, 200, 300, 150, 250, 100, 1023));
        charge_session(560, 150, 4, 8, 0, 0);
        drain_ticks();
        apply_settings(mk_settings($urandom_range(0, 255), $urandom_range(0, 4095),
                                   $urandom_range(0, 1023), $urandom_range(0, 1023),
                                   $urandom_range(0, 1023), $urandom_range(0, 1023),
                                   $urandom_range(0, 1023), $urandom_range(0, 1023)));
        calm = 1'b1;
        charge_session(80, $urandom_range(0, 900), 2, 50, 15, 20);
        drain_ticks();
        repeat (4) @(posedge clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/tccc_pkg.sv
sv/tccc_if.sv
sv/two_cell_cc_cv_charger_top.sv
dv/charge_check.sv
dv/testbench.sv
